FILE: hdl/lpht_pkg.sv
// Package for the linear probe hash table: sizes, status codes, register indexes.
// No dependencies.
package lpht_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int KEY_WIDTH   = 64;
    localparam int VALUE_WIDTH = 64;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BYTES_MAX = KEY_WIDTH / 8;
    localparam int VAL_BYTES_MAX = VALUE_WIDTH / 8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UPDATED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] ACT_PUT     = 2'd0;
    localparam logic [1:0] ACT_GET     = 2'd1;
    localparam logic [1:0] ACT_REMOVE  = 2'd2;
    localparam logic [1:0] ACT_INVALID = 2'd3;

    localparam logic [1:0] REG_SLOT_COUNT  = 2'd0;
    localparam logic [1:0] REG_KEY_BYTES   = 2'd1;
    localparam logic [1:0] REG_VALUE_BYTES = 2'd2;
    localparam logic [1:0] REG_UNUSED      = 2'd3;
endpackage

FILE: hdl/linear_probe_hash_table_top.sv
// Top level of the linear probe hash table: sequencer, hash unit, modulo unit, slot store.
// Depends on lpht_pkg.
//
// One request (put, get, remove) is taken at a time; s_tready is low until its result word
// has been handed on. The key is hashed one byte per cycle, the hash is
// reduced by a restoring divider one quotient bit per cycle, and the probe walk
// reads one slot at a time (read, then compare) up to one lap of slot_count slots.
// A remove then runs backward-shift deletion, which rehashes each following entry with the
// same shared hash and modulo units.
// Occupancy is held in one flip-flop per slot and cleared at reset, so no clearing
// pass is needed.
module linear_probe_hash_table_top
    import lpht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: action[1:0], key[65:2], value[129:66], zero fill to 136 bits
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], found_value[65:2], zero fill to 72 bits
    output logic [71:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_MOD, S_RD, S_CMP, S_SB_RD, S_SB_CHK, S_SB_HASH, S_SB_MOD,
        S_SB_DEC, S_OUT
    } state_t;

    state_t state_reg;
    logic [8:0] slot_count_reg;
    logic [3:0] key_bytes_reg, value_bytes_reg;

    // effective configuration
    logic [CNT_W-1:0] n_eff;
    logic [3:0] kb_eff, vb_eff;
    always_comb
    begin
        if (slot_count_reg == 9'd0) n_eff = CNT_W'(1);
        else if ({23'd0, slot_count_reg} > TABLE_DEPTH) n_eff = CNT_W'(TABLE_DEPTH);
        else n_eff = CNT_W'(slot_count_reg);
        if (key_bytes_reg == 4'd0) kb_eff = 4'd1;
        else if ({28'd0, key_bytes_reg} > KEY_BYTES_MAX) kb_eff = 4'(KEY_BYTES_MAX);
        else kb_eff = key_bytes_reg;
        if (value_bytes_reg == 4'd0) vb_eff = 4'd1;
        else if ({28'd0, value_bytes_reg} > VAL_BYTES_MAX) vb_eff = 4'(VAL_BYTES_MAX);
        else vb_eff = value_bytes_reg;
    end

    function automatic logic [63:0] bmask(input logic [3:0] nb);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
            if (i < nb) m[i*8 +: 8] = 8'hff;
        return m;
    endfunction

    // storage
    logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] val_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] occ_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic                   rd_occ_reg;

    // request and walk registers
    logic [1:0]  act_reg;
    logic [63:0] key_reg, val_reg, hkey_reg;
    logic [31:0] hash_reg, rem_reg;
    logic [3:0]  byte_reg;
    logic [5:0]  bit_reg;
    logic [SLOT_W-1:0] slot_reg, hole_reg, home_reg;
    logic [CNT_W-1:0]  step_reg;
    logic [1:0]  status_reg;
    logic [63:0] found_reg;

    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en, mv_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [63:0]       wr_key, wr_val;

    logic [SLOT_W-1:0] slot_inc;
    assign slot_inc = ({1'b0, slot_reg} + 1'b1 == (SLOT_W+1)'(n_eff)) ? '0 : slot_reg + 1'b1;

    logic [32:0] rem_sh;
    assign rem_sh = {rem_reg, hash_reg[31]};
    logic [7:0] hbyte;
    assign hbyte = hkey_reg[byte_reg[2:0]*8 +: 8];

    logic stays;
    always_comb
    begin
        if (hole_reg <= slot_reg) stays = (hole_reg < home_reg) && (home_reg <= slot_reg);
        else stays = (hole_reg < home_reg) || (home_reg <= slot_reg);
    end

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {6'd0, found_reg, status_reg};

    // memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    always_comb
    begin
        rd_addr = slot_reg;
        wr_en = 1'b0;
        mv_en = 1'b0;
        wr_addr = slot_reg;
        wr_key = key_reg;
        wr_val = val_reg;
        if (state_reg == S_CMP && rd_occ_reg && act_reg == ACT_PUT && rd_key_reg == key_reg)
        begin
            wr_en = 1'b1;
            wr_key = rd_key_reg;
        end
        else if (state_reg == S_CMP && !rd_occ_reg && act_reg == ACT_PUT)
            wr_en = 1'b1;
        else if (state_reg == S_SB_DEC && !stays)
        begin
            wr_en = 1'b1;
            mv_en = 1'b1;
            wr_addr = hole_reg;
            wr_key = hkey_reg;
            wr_val = rd_val_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_count_reg <= 9'd256;
            key_bytes_reg <= 4'd8;
            value_bytes_reg <= 4'd8;
            occ_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            rd_occ_reg <= occ_reg[rd_addr];
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            REG_SLOT_COUNT:  slot_count_reg <= cfg_data[8:0];
                            REG_KEY_BYTES:   key_bytes_reg <= cfg_data[3:0];
                            REG_VALUE_BYTES: value_bytes_reg <= cfg_data[3:0];
                            default: ;
                        endcase
                    end
                    else if (s_tvalid)
                    begin
                        act_reg <= s_tdata[1:0];
                        key_reg <= s_tdata[65:2] & bmask(kb_eff);
                        hkey_reg <= s_tdata[65:2] & bmask(kb_eff);
                        val_reg <= s_tdata[129:66] & bmask(vb_eff);
                        hash_reg <= '0;
                        byte_reg <= '0;
                        found_reg <= '0;
                        status_reg <= ST_NOTFOUND;
                        if (s_tdata[1:0] == ACT_INVALID)
                            state_reg <= S_OUT;
                        else if (s_tdata[1:0] == ACT_PUT && count_reg >= n_eff)
                        begin
                            status_reg <= ST_FULL;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_HASH;
                    end
                end
                S_HASH, S_SB_HASH:
                begin
                    // one byte per cycle: h = h*33 + b
                    hash_reg <= (hash_reg << 5) + hash_reg + {24'd0, hbyte};
                    byte_reg <= byte_reg + 1'b1;
                    if (byte_reg + 1'b1 == kb_eff)
                    begin
                        rem_reg <= '0;
                        bit_reg <= '0;
                        state_reg <= (state_reg == S_HASH) ? S_MOD : S_SB_MOD;
                    end
                end
                S_MOD, S_SB_MOD:
                begin
                    // restoring remainder, one bit per cycle
                    hash_reg <= hash_reg << 1;
                    if (rem_sh >= {{(33-CNT_W){1'b0}}, n_eff})
                        rem_reg <= 32'(rem_sh - {{(33-CNT_W){1'b0}}, n_eff});
                    else
                        rem_reg <= rem_sh[31:0];
                    bit_reg <= bit_reg + 1'b1;
                    if (bit_reg == 6'd31)
                    begin
                        if (state_reg == S_MOD)
                        begin
                            slot_reg <= (rem_sh >= {{(33-CNT_W){1'b0}}, n_eff}) ?
                                SLOT_W'(rem_sh - {{(33-CNT_W){1'b0}}, n_eff}) :
                                SLOT_W'(rem_sh);
                            step_reg <= '0;
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            home_reg <= (rem_sh >= {{(33-CNT_W){1'b0}}, n_eff}) ?
                                SLOT_W'(rem_sh - {{(33-CNT_W){1'b0}}, n_eff}) :
                                SLOT_W'(rem_sh);
                            state_reg <= S_SB_DEC;
                        end
                    end
                end
                S_RD: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (!rd_occ_reg)
                    begin
                        if (act_reg == ACT_PUT)
                        begin
                            occ_reg[slot_reg] <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                            status_reg <= ST_OK;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (rd_key_reg == key_reg)
                    begin
                        if (act_reg == ACT_PUT)
                        begin
                            status_reg <= ST_UPDATED;
                            state_reg <= S_OUT;
                        end
                        else if (act_reg == ACT_GET)
                        begin
                            found_reg <= rd_val_reg;
                            status_reg <= ST_OK;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            occ_reg[slot_reg] <= 1'b0;
                            if (count_reg != '0) count_reg <= count_reg - 1'b1;
                            status_reg <= ST_OK;
                            hole_reg <= slot_reg;
                            step_reg <= CNT_W'(1);
                            slot_reg <= slot_inc;
                            state_reg <= (n_eff == CNT_W'(1)) ? S_OUT : S_SB_RD;
                        end
                    end
                    else if (step_reg + 1'b1 == n_eff)
                    begin
                        if (act_reg == ACT_PUT) status_reg <= ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        slot_reg <= slot_inc;
                        state_reg <= S_RD;
                    end
                end
                S_SB_RD: state_reg <= S_SB_CHK;
                S_SB_CHK:
                begin
                    if (!rd_occ_reg) state_reg <= S_OUT;
                    else
                    begin
                        hkey_reg <= rd_key_reg;
                        hash_reg <= '0;
                        byte_reg <= '0;
                        state_reg <= S_SB_HASH;
                    end
                end
                S_SB_DEC:
                begin
                    // move entry into the hole unless its home lies in (hole, j]
                    if (mv_en)
                    begin
                        occ_reg[hole_reg] <= 1'b1;
                        occ_reg[slot_reg] <= 1'b0;
                        hole_reg <= slot_reg;
                    end
                    if (step_reg + 1'b1 == n_eff) state_reg <= S_OUT;
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        slot_reg <= slot_inc;
                        state_reg <= S_SB_RD;
                    end
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // a result word is held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    // no request is taken while one is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_tready)
        else $error("input accepted while busy");
    // entry count never exceeds the table depth
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count overflow");
    // found value is zero unless a get succeeds
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status_reg != ST_OK |-> found_reg == '0)
        else $error("found value set on failed request");
endmodule
